FILE: sv/wsld_pkg.sv
// Shared types, constants and register map of the wheel slip latch detector.
// Used by the channel interfaces and by every module of the block.
package wsld_pkg;

    localparam int WINDOW_MAX_DEF = 16;
    localparam int DATA_W         = 16;
    localparam int LEN_W          = 5;
    localparam int KIND_W         = 2;
    localparam int DIV_W          = 32;
    localparam int DIVR_W         = 16;
    localparam int SLIP_FRAC      = 15;
    localparam int PADDR_W        = 5;
    localparam int PDATA_W        = 32;
    localparam int REG_IDX_W      = 3;

    localparam logic [REG_IDX_W-1:0] REG_WHEEL_MOVING  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_VEHICLE_STILL = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LATCH_SLIP    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RELEASE_SPEED = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SLIP_LEN      = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SPEED_LEN     = 3'd5;

    localparam logic [DATA_W-1:0] RST_WHEEL_MOVING  = 16'd100;
    localparam logic [DATA_W-1:0] RST_VEHICLE_STILL = 16'd70;
    localparam logic [DATA_W-1:0] RST_LATCH_SLIP    = 16'd26214;
    localparam logic [DATA_W-1:0] RST_RELEASE_SPEED = 16'd60;
    localparam logic [LEN_W-1:0]  RST_SLIP_LEN      = 5'd10;
    localparam logic [LEN_W-1:0]  RST_SPEED_LEN     = 5'd10;

    typedef enum logic [KIND_W-1:0] {
        KIND_WHEEL   = 2'd0,
        KIND_VEHICLE = 2'd1,
        KIND_TICK    = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPD_PUSH,
        ST_SPD_DIV,
        ST_SLIP_DIV,
        ST_SLIP_PUSH,
        ST_SLIP_MEAN_DIV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [DATA_W-1:0] wheel_moving;
        logic [DATA_W-1:0] vehicle_still;
        logic [DATA_W-1:0] latch_slip;
        logic [DATA_W-1:0] release_speed;
        logic [LEN_W-1:0]  slip_len;
        logic [LEN_W-1:0]  speed_len;
    } t_cfg;

    typedef struct packed {
        logic              spd_push;
        logic              slip_push;
        logic [DATA_W-1:0] slip_val;
        logic              div_start;
        logic [DIV_W-1:0]  dividend;
        logic [DIVR_W-1:0] divisor;
        logic              out_load;
    } t_seq_ctrl;

endpackage

FILE: sv/wsld_in_if.sv
// Input channel of the wheel slip latch detector: valid/ready plus one item.
// Depends on wsld_pkg for field widths.
interface wsld_in_if import wsld_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic signed [DATA_W-1:0] wheel_spd;
    logic [DATA_W-1:0]   vehicle_speed;

    modport source (output valid, kind, wheel_spd, vehicle_speed, input ready);
    modport sink   (input valid, kind, wheel_spd, vehicle_speed, output ready);
endinterface

FILE: sv/wsld_res_if.sv
// Result channel of the wheel slip latch detector: valid/ready plus one result.
// Depends on wsld_pkg for field widths.
interface wsld_res_if import wsld_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] slip_now;
    logic [DATA_W-1:0] slip_mean;
    logic              slip_latched;
    logic [DATA_W-1:0] last_vehicle_speed;
    logic [DATA_W-1:0] vehicle_speed_mean;

    modport source (output valid, slip_now, slip_mean, slip_latched, last_vehicle_speed,
                    vehicle_speed_mean, input ready);
    modport sink   (input valid, slip_now, slip_mean, slip_latched, last_vehicle_speed,
                    vehicle_speed_mean, output ready);
endinterface

FILE: sv/wsld_cfg.sv
// APB-style configuration register bank: thresholds and window lengths.
// Depends on wsld_pkg for the register map and reset values.
module wsld_cfg import wsld_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);
    t_cfg                 r_cfg;
    logic [REG_IDX_W-1:0] w_idx;
    logic                 w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[PADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wheel_moving  <= RST_WHEEL_MOVING;
            r_cfg.vehicle_still <= RST_VEHICLE_STILL;
            r_cfg.latch_slip    <= RST_LATCH_SLIP;
            r_cfg.release_speed <= RST_RELEASE_SPEED;
            r_cfg.slip_len      <= RST_SLIP_LEN;
            r_cfg.speed_len     <= RST_SPEED_LEN;
        end else if (w_wr) begin
            case (w_idx)
                REG_WHEEL_MOVING:  r_cfg.wheel_moving  <= pwdata[DATA_W-1:0];
                REG_VEHICLE_STILL: r_cfg.vehicle_still <= pwdata[DATA_W-1:0];
                REG_LATCH_SLIP:    r_cfg.latch_slip    <= pwdata[DATA_W-1:0];
                REG_RELEASE_SPEED: r_cfg.release_speed <= pwdata[DATA_W-1:0];
                REG_SLIP_LEN:      r_cfg.slip_len      <= pwdata[LEN_W-1:0];
                REG_SPEED_LEN:     r_cfg.speed_len     <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_WHEEL_MOVING:  prdata = PDATA_W'(r_cfg.wheel_moving);
            REG_VEHICLE_STILL: prdata = PDATA_W'(r_cfg.vehicle_still);
            REG_LATCH_SLIP:    prdata = PDATA_W'(r_cfg.latch_slip);
            REG_RELEASE_SPEED: prdata = PDATA_W'(r_cfg.release_speed);
            REG_SLIP_LEN:      prdata = PDATA_W'(r_cfg.slip_len);
            REG_SPEED_LEN:     prdata = PDATA_W'(r_cfg.speed_len);
            default:           prdata = '0;
        endcase
    end
endmodule

FILE: sv/wsld_win.sv
// Running-mean window: ring memory with fill count, head pointer and sum.
// A push reads the oldest entry, then updates; depends on wsld_pkg.
module wsld_win import wsld_pkg::*; #(
    parameter  int WINDOW_MAX = WINDOW_MAX_DEF,
    localparam int IDX_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1,
    localparam int FILL_W = $clog2(WINDOW_MAX + 1),
    localparam int SUM_W  = DATA_W + IDX_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_val,
    input  logic [LEN_W-1:0]  i_len,
    output logic [SUM_W-1:0]  o_sum,
    output logic [FILL_W-1:0] o_fill,
    output logic              o_done
);
    localparam int CMP_W = (FILL_W > LEN_W) ? FILL_W : LEN_W;
    localparam int OW    = FILL_W + 1;

    logic [DATA_W-1:0] r_ring [WINDOW_MAX];
    logic [DATA_W-1:0] r_rd;
    logic [DATA_W-1:0] r_val;
    logic              r_drop;
    logic              r_phase;
    logic              r_done;
    logic [FILL_W-1:0] r_fill;
    logic [IDX_W-1:0]  r_head;
    logic [SUM_W-1:0]  r_sum;

    logic [CMP_W-1:0]  w_len;
    logic              w_drop;
    logic [OW-1:0]     w_old;
    logic [IDX_W-1:0]  w_old_idx;
    logic [IDX_W-1:0]  w_head_nx;

    always_comb begin
        if (i_len == '0) begin
            w_len = CMP_W'(1);
        end else if (CMP_W'(i_len) > CMP_W'(WINDOW_MAX)) begin
            w_len = CMP_W'(WINDOW_MAX);
        end else begin
            w_len = CMP_W'(i_len);
        end
        w_drop = CMP_W'(r_fill) >= w_len;
        w_old  = OW'(r_head) + OW'(WINDOW_MAX) - OW'(r_fill);
        if (w_old >= OW'(WINDOW_MAX)) begin
            w_old = w_old - OW'(WINDOW_MAX);
        end
        w_old_idx = IDX_W'(w_old);
        if (r_head == IDX_W'(WINDOW_MAX - 1)) begin
            w_head_nx = '0;
        end else begin
            w_head_nx = r_head + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_rd   <= r_ring[w_old_idx];
            r_val  <= i_val;
            r_drop <= w_drop;
        end
        if (r_phase) begin
            r_ring[r_head] <= r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
            r_done  <= 1'b0;
            r_fill  <= '0;
            r_head  <= '0;
            r_sum   <= '0;
        end else begin
            r_phase <= i_push;
            r_done  <= r_phase;
            if (r_phase) begin
                r_sum  <= r_sum - (r_drop ? SUM_W'(r_rd) : '0) + SUM_W'(r_val);
                r_fill <= r_fill - FILL_W'(r_drop) + FILL_W'(1);
                r_head <= w_head_nx;
            end
        end
    end

    assign o_sum  = r_sum;
    assign o_fill = r_fill;
    assign o_done = r_done;
endmodule

FILE: sv/wsld_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on wsld_pkg for the dividend and divisor widths.
module wsld_div import wsld_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_W-1:0]  i_dividend,
    input  logic [DIVR_W-1:0] i_divisor,
    output logic              o_busy,
    output logic              o_done,
    output logic [DIV_W-1:0]  o_quot
);
    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIVR_W-1:0] r_rem;
    logic [DIV_W-1:0]  r_quo;
    logic [DIVR_W-1:0] r_dvs;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DIVR_W:0]   w_sh;
    logic [DIVR_W:0]   w_diff;
    logic              w_ge;
    logic [DIVR_W-1:0] w_rem;

    always_comb begin
        w_sh   = {r_rem, r_quo[DIV_W-1]};
        w_diff = w_sh - {1'b0, r_dvs};
        w_ge   = w_sh >= {1'b0, r_dvs};
        w_rem  = w_ge ? w_diff[DIVR_W-1:0] : w_sh[DIVR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_rem;
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quo;
endmodule

FILE: sv/wheel_slip_latch_detector.sv
// Wheel slip latch detector top level: sequencer, result register, assertions.
// Depends on wsld_pkg, wsld_in_if, wsld_res_if, wsld_cfg, wsld_win, wsld_div.
//
// Items arrive on i_in (valid/ready); a beat is taken when both are high.
// Kind 0 stores the wheel speed magnitude and kind 3 is dropped; either frees
// the input on the next cycle. Kind 1 pushes a vehicle speed sample into the
// speed window and divides the window sum by its fill before the next beat
// can be taken. Kind 2 (tick) pushes the slip into the slip window, divides
// for the mean, updates the latch and loads the result register; when the
// wheels turn, the vehicle is still and the slip ratio takes a division of
// its own, that division comes before the push. The result beat is offered
// from the cycle after the load. The single shared one-bit-per-cycle
// divider serves every division in turn; i_in.ready is low while an item is
// at work.
// Each result is held in an output register until taken; a stalled receiver
// blocks the next tick at its load step, and the input with it.
// Registers sit on the APB port, byte address 4*i, pready always high.
// Synchronous reset clears windows, speeds, latch and restores register
// defaults; no clearing pass is needed.
module wheel_slip_latch_detector import wsld_pkg::*; #(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    wsld_in_if.sink            i_in,
    wsld_res_if.source         o_res
);
    localparam int IDX_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int FILL_W = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W  = DATA_W + IDX_W;

    t_cfg              w_cfg;
    t_seq_ctrl         w_ctrl;
    t_state            r_state;
    t_state            n_state;

    logic [SUM_W-1:0]  w_spd_sum;
    logic [FILL_W-1:0] w_spd_fill;
    logic              w_spd_done;
    logic [SUM_W-1:0]  w_slip_sum;
    logic [FILL_W-1:0] w_slip_fill;
    logic              w_slip_done;
    logic              w_div_busy;
    logic              w_div_done;
    logic [DIV_W-1:0]  w_quot;

    logic [DATA_W-1:0] r_wheel_mag;
    logic [DATA_W-1:0] r_latest;
    logic [DATA_W-1:0] r_speed_mean;
    logic [DATA_W-1:0] r_slip;
    logic [DATA_W-1:0] r_avg;
    logic              r_latch;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_o_slip;
    logic [DATA_W-1:0] r_o_mean;
    logic              r_o_latch;
    logic [DATA_W-1:0] r_o_last;
    logic [DATA_W-1:0] r_o_vmean;

    logic              w_fire;
    logic              w_is_wheel;
    logic              w_is_veh;
    logic              w_is_tick;
    logic              w_slip_cond;
    logic [DATA_W-1:0] w_abs;
    logic [DATA_W-1:0] w_diff;

    wsld_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    wsld_win #(.WINDOW_MAX(WINDOW_MAX)) u_spd_win (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_ctrl.spd_push),
        .i_val   (i_in.vehicle_speed),
        .i_len   (w_cfg.speed_len),
        .o_sum   (w_spd_sum),
        .o_fill  (w_spd_fill),
        .o_done  (w_spd_done)
    );

    wsld_win #(.WINDOW_MAX(WINDOW_MAX)) u_slip_win (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_ctrl.slip_push),
        .i_val   (w_ctrl.slip_val),
        .i_len   (w_cfg.slip_len),
        .o_sum   (w_slip_sum),
        .o_fill  (w_slip_fill),
        .o_done  (w_slip_done)
    );

    wsld_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_ctrl.div_start),
        .i_dividend (w_ctrl.dividend),
        .i_divisor  (w_ctrl.divisor),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    assign i_in.ready  = (r_state == ST_IDLE);
    assign w_fire      = i_in.valid && i_in.ready;
    assign w_is_wheel  = w_fire && (i_in.kind == KIND_WHEEL);
    assign w_is_veh    = w_fire && (i_in.kind == KIND_VEHICLE);
    assign w_is_tick   = w_fire && (i_in.kind == KIND_TICK);
    assign w_abs       = i_in.wheel_spd[DATA_W-1] ? DATA_W'(-i_in.wheel_spd)
                                                  : DATA_W'(i_in.wheel_spd);
    assign w_diff      = r_wheel_mag - r_speed_mean;
    assign w_slip_cond = (r_wheel_mag > w_cfg.wheel_moving)
                      && (r_speed_mean < w_cfg.vehicle_still)
                      && (r_wheel_mag > r_speed_mean);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_is_veh) begin
                    n_state = ST_SPD_PUSH;
                end else if (w_is_tick) begin
                    n_state = w_slip_cond ? ST_SLIP_DIV : ST_SLIP_PUSH;
                end
            end
            ST_SPD_PUSH:      if (w_spd_done)  n_state = ST_SPD_DIV;
            ST_SPD_DIV:       if (w_div_done)  n_state = ST_IDLE;
            ST_SLIP_DIV:      if (w_div_done)  n_state = ST_SLIP_PUSH;
            ST_SLIP_PUSH:     if (w_slip_done) n_state = ST_SLIP_MEAN_DIV;
            ST_SLIP_MEAN_DIV: if (w_div_done)  n_state = ST_EMIT;
            ST_EMIT:          if (w_ctrl.out_load) n_state = ST_IDLE;
            default:          n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_ctrl.spd_push  = w_is_veh;
        w_ctrl.slip_push = (w_is_tick && !w_slip_cond)
                        || ((r_state == ST_SLIP_DIV) && w_div_done);
        w_ctrl.slip_val  = (r_state == ST_SLIP_DIV) ? w_quot[DATA_W-1:0] : '0;
        w_ctrl.out_load  = (r_state == ST_EMIT) && (!r_out_valid || o_res.ready);
        case (r_state)
            ST_SPD_PUSH: begin
                w_ctrl.div_start = w_spd_done;
                w_ctrl.dividend  = DIV_W'(w_spd_sum);
                w_ctrl.divisor   = DIVR_W'(w_spd_fill);
            end
            ST_SLIP_PUSH: begin
                w_ctrl.div_start = w_slip_done;
                w_ctrl.dividend  = DIV_W'(w_slip_sum);
                w_ctrl.divisor   = DIVR_W'(w_slip_fill);
            end
            default: begin
                w_ctrl.div_start = w_is_tick && w_slip_cond;
                w_ctrl.dividend  = DIV_W'({w_diff, SLIP_FRAC'(0)});
                w_ctrl.divisor   = r_wheel_mag;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_wheel_mag  <= '0;
            r_latest     <= '0;
            r_speed_mean <= '0;
            r_latch      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_is_wheel) begin
                r_wheel_mag <= w_abs;
            end
            if (w_is_veh) begin
                r_latest <= i_in.vehicle_speed;
            end
            if ((r_state == ST_SPD_DIV) && w_div_done) begin
                r_speed_mean <= w_quot[DATA_W-1:0];
            end
            if ((r_state == ST_SLIP_MEAN_DIV) && w_div_done) begin
                if (!r_latch) begin
                    r_latch <= w_quot[DATA_W-1:0] > w_cfg.latch_slip;
                end else if ((r_speed_mean > w_cfg.release_speed)
                          && (r_wheel_mag > w_cfg.release_speed)) begin
                    r_latch <= 1'b0;
                end
            end
            if (w_ctrl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_is_tick && !w_slip_cond) begin
            r_slip <= '0;
        end else if ((r_state == ST_SLIP_DIV) && w_div_done) begin
            r_slip <= w_quot[DATA_W-1:0];
        end
        if ((r_state == ST_SLIP_MEAN_DIV) && w_div_done) begin
            r_avg <= w_quot[DATA_W-1:0];
        end
        if (w_ctrl.out_load) begin
            r_o_slip  <= r_slip;
            r_o_mean  <= r_avg;
            r_o_latch <= r_latch;
            r_o_last  <= r_latest;
            r_o_vmean <= r_speed_mean;
        end
    end

    assign o_res.valid              = r_out_valid;
    assign o_res.slip_now           = r_o_slip;
    assign o_res.slip_mean          = r_o_mean;
    assign o_res.slip_latched       = r_o_latch;
    assign o_res.last_vehicle_speed = r_o_last;
    assign o_res.vehicle_speed_mean = r_o_vmean;

`ifndef SYNTH
    a_div_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.div_start |-> !w_div_busy)
        else $error("divider started while busy");

    a_slip_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_o_slip <= DATA_W'(1 << SLIP_FRAC))
                      && (r_o_mean <= DATA_W'(1 << SLIP_FRAC))))
        else $error("slip result above full scale");

    a_latch_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_latch) |-> ($past(r_state) == ST_SLIP_MEAN_DIV))
        else $error("latch set outside slip mean update");
`endif
endmodule
